@@ rtl/core/sbsp_pkg.sv @@
package sbsp_pkg;

  localparam int MASK_BITS_DEF  = 256;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int MASK_WORD_W    = 64;
  localparam int MASK_SPAN      = 256;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDE  = 3'd0,
    REG_CHAN  = 3'd1,
    REG_TEXT  = 3'd2,
    REG_MASK0 = 3'd3,
    REG_MASK1 = 3'd4,
    REG_MASK2 = 3'd5,
    REG_MASK3 = 3'd6
  } reg_idx_e;

  localparam logic       WIDE_RST = 1'b1;
  localparam logic [4:0] CHAN_RST = 5'd2;
  localparam logic       TEXT_RST = 1'b0;
  // byte lane of the top frame position for the reset layout
  localparam logic [4:0] LANE_RST = WIDE_RST ? 5'(2 * CHAN_RST - 1) : 5'(CHAN_RST - 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] pad;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/core/sbsp_fifo.sv @@
module sbsp_fifo import sbsp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  entry_t     entry_i,
  input  logic       pop_i,
  output entry_t     entry_o,
  output fifo_stat_t stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/core/sbsp_front.sv @@
module sbsp_front import sbsp_pkg::*; #(
  parameter int MASK_BITS = MASK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_cmd_i,
  input  logic [15:0]           in_sample_i,
  input  fifo_stat_t            fifo_stat_i,
  output logic                  push_o,
  output entry_t                push_entry_o,
  output logic                  text_mode_o
);

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [6:0] acc;
    logic [2:0] cnt;
  } chunk_t;

  // shift the selected bits of one byte into the packer, top bit first
  function automatic chunk_t pack_chunk(logic [6:0] acc, logic [2:0] cnt,
                                        logic [7:0] d, logic [7:0] m);
    logic [14:0] tmp;
    logic [3:0]  c;
    chunk_t      r;
    tmp = {8'h00, acc};
    c   = {1'b0, cnt};
    for (int b = 7; b >= 0; b--) begin
      if (m[b]) begin
        tmp = {tmp[13:0], d[b]};
        c   = c + 4'd1;
      end
    end
    r.emit = c[3];
    r.data = 8'(tmp >> c[2:0]);
    r.acc  = tmp[6:0] & ~(7'h7F << c[2:0]);
    r.cnt  = c[2:0];
    return r;
  endfunction

  logic                 wide_q, wide_d;
  logic [4:0]           chan_q, chan_d;
  logic                 text_q, text_d;
  logic [MASK_BITS-1:0] mask_q, mask_d;
  logic [6:0]           acc_q, acc_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [4:0]           lane_q, lane_d;
  logic                 lo_pend_q, lo_pend_d;
  logic [7:0]           lo_data_q, lo_data_d;
  logic [7:0]           lo_mask_q, lo_mask_d;

  logic [MASK_SPAN-1:0] mask_ext;
  logic [4:0]           ch_eff;
  logic [4:0]           reload;
  logic [4:0]           lane_next;
  logic [7:0]           mask_hi, mask_lo;
  logic                 accept, lo_step;
  logic [3:0]           lo_sum;
  chunk_t               ck;

  for (genvar j = 0; j < MASK_SPAN; j++) begin : g_mask
    if (j < MASK_BITS) begin : g_in
      assign mask_ext[j] = mask_q[j];
    end else begin : g_out
      assign mask_ext[j] = 1'b0;
    end
  end

  assign mask_hi = mask_ext[{lane_q, 3'b000} +: 8];
  assign mask_lo = mask_ext[{lane_q[4:1], 4'b0000} +: 8];

  assign in_ready_o  = !lo_pend_q && !fifo_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;
  assign lo_step     = lo_pend_q && !fifo_stat_i.full;
  assign text_mode_o = text_q;

  // frame layout after this cycle's configuration write
  always_comb begin
    if (chan_d == 5'd0) begin
      ch_eff = 5'd1;
    end else if (chan_d > 5'd16) begin
      ch_eff = 5'd16;
    end else begin
      ch_eff = chan_d;
    end
    reload    = wide_d ? 5'({1'b0, ch_eff, 1'b0} - 7'd1) : ch_eff - 5'd1;
    lane_next = (lane_q == 5'd0) ? reload : lane_q - 5'd1;
  end

  always_comb begin
    wide_d = wide_q;
    chan_d = chan_q;
    text_d = text_q;
    mask_d = mask_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WIDE: wide_d = cfg_wdata_i[0];
        REG_CHAN: chan_d = cfg_wdata_i[4:0];
        REG_TEXT: text_d = cfg_wdata_i[0];
        default: ;
      endcase
      for (int j = 0; j < MASK_BITS; j++) begin
        if (cfg_addr_i == CFG_ADDR_W'(int'(REG_MASK0) + j / MASK_WORD_W)) begin
          mask_d[j] = cfg_wdata_i[j % MASK_WORD_W];
        end
      end
    end
  end

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    lane_d       = lane_q;
    lo_pend_d    = lo_pend_q;
    lo_data_d    = lo_data_q;
    lo_mask_d    = lo_mask_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    ck           = pack_chunk(acc_q, cnt_q,
                              lo_pend_q ? lo_data_q
                                        : (wide_q ? in_sample_i[15:8] : in_sample_i[7:0]),
                              lo_pend_q ? lo_mask_q : mask_hi);
    lo_sum       = {1'b0, ck.cnt} + 4'($countones(mask_lo));

    if (lo_step) begin
      push_o            = ck.emit;
      push_entry_o.data = ck.data;
      push_entry_o.last = 1'b1;
      acc_d             = ck.acc;
      cnt_d             = ck.cnt;
      lane_d            = lane_next;
      lo_pend_d         = 1'b0;
    end else if (accept && in_cmd_i) begin
      // flush: pad the partial byte at the low end
      push_o            = (cnt_q != 3'd0);
      push_entry_o.data = 8'({1'b0, acc_q} << (3'd0 - cnt_q));
      push_entry_o.pad  = 3'd0 - cnt_q;
      push_entry_o.last = 1'b1;
      acc_d             = '0;
      cnt_d             = '0;
      lane_d            = reload;
    end else if (accept) begin
      push_o            = ck.emit;
      push_entry_o.data = ck.data;
      // the low half completes another byte only if it gathers enough bits
      push_entry_o.last = !(wide_q && lo_sum[3]);
      acc_d             = ck.acc;
      cnt_d             = ck.cnt;
      lane_d            = lane_next;
      lo_pend_d         = wide_q;
      lo_data_d         = in_sample_i[7:0];
      lo_mask_d         = mask_lo;
    end

    if (cfg_we_i && (cfg_addr_i == REG_WIDE || cfg_addr_i == REG_CHAN)) begin
      lane_d = reload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q    <= WIDE_RST;
      chan_q    <= CHAN_RST;
      text_q    <= TEXT_RST;
      mask_q    <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      lane_q    <= LANE_RST;
      lo_pend_q <= 1'b0;
    end else begin
      wide_q    <= wide_d;
      chan_q    <= chan_d;
      text_q    <= text_d;
      mask_q    <= mask_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      lane_q    <= lane_d;
      lo_pend_q <= lo_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_data_q <= lo_data_d;
    lo_mask_q <= lo_mask_d;
  end

endmodule

@@ rtl/core/sbsp_back.sv @@
module sbsp_back import sbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fifo_stat_t fifo_stat_i,
  input  entry_t     fifo_entry_i,
  output logic       pop_o,
  input  logic       text_mode_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] out_pad_o,
  output logic       out_last_o
);

  logic       vld_q, vld_d;
  entry_t     ent_q, ent_d;
  logic [2:0] idx_q, idx_d;
  logic       beat, final_beat;

  assign beat       = vld_q && out_ready_i;
  assign final_beat = !text_mode_i || (idx_q == 3'd7);
  assign pop_o      = !fifo_stat_i.empty && (!vld_q || (beat && final_beat));

  always_comb begin
    vld_d = vld_q;
    ent_d = ent_q;
    idx_d = idx_q;
    if (pop_o) begin
      vld_d = 1'b1;
      ent_d = fifo_entry_i;
      idx_d = '0;
    end else if (beat) begin
      if (final_beat) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // text mode walks the byte top bit first, one character a beat
  assign out_valid_o = vld_q;
  assign out_byte_o  = text_mode_i ? (ent_q.data[3'd7 - idx_q] ? CHAR_ONE : CHAR_ZERO)
                                   : ent_q.data;
  assign out_pad_o   = ent_q.pad;
  assign out_last_o  = ent_q.last && final_beat;

endmodule

@@ rtl/core/sample_bit_select_packer_core.sv @@
// An accepted sample is packed, queued and then loaded into the output register; when
// only the low byte of a 16-bit sample completes a byte, it comes from a second pass
// (one packing pass per sample byte) that holds off the next sample. Raw bytes leave at
// one a cycle while the output is ready, text mode at eight characters a byte, set by the
// output register; a four-entry queue between packer and output absorbs the bursts.
// Reset: asynchronous active low; clears packer, queue and output, loads default config.
module sample_bit_select_packer_core import sbsp_pkg::*; #(
  parameter int MASK_BITS  = MASK_BITS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [15:0]           s_axis_tdata_i,  // [15:0] sample
  input  logic                  s_axis_tuser_i,  // [0] cmd
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,  // [7:0] out_byte
  output logic [2:0]            m_axis_tuser_o,  // [2:0] pad_count
  output logic                  m_axis_tlast_o
);

  logic       push, pop, text_mode;
  entry_t     push_entry, head_entry;
  fifo_stat_t fifo_stat;

  sbsp_front #(
    .MASK_BITS(MASK_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_sample_i (s_axis_tdata_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_entry_o(push_entry),
    .text_mode_o (text_mode)
  );

  sbsp_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .stat_o (fifo_stat)
  );

  sbsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .fifo_entry_i(head_entry),
    .pop_o       (pop),
    .text_mode_i (text_mode),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_pad_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

@@ rtl/core/sbsp_checker.sv @@
module sbsp_checker import sbsp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [15:0]           s_axis_tdata_i,
  input logic                  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [7:0]            m_axis_tdata_o,
  input logic [2:0]            m_axis_tuser_o,
  input logic                  m_axis_tlast_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // a padded raw byte is the flush's only result and has zero low bits
  a_pad_raw_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != 3'd0 &&
    m_axis_tdata_o != CHAR_ZERO && m_axis_tdata_o != CHAR_ONE |->
      m_axis_tlast_o && ((m_axis_tdata_o & ~(8'hFF << m_axis_tuser_o)) == 8'h00))
    else $error("padded byte malformed");

endmodule

bind sample_bit_select_packer_core sbsp_checker u_sbsp_checker (.*);
